// File: sv/cctd_pkg.sv
// ----------------------------------------------------------------------------
// Conflict count table package
// Shared constants, request codes, record layout and control structs.
// ----------------------------------------------------------------------------
package cctd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;

  localparam int COORD_W = 16;
  localparam int TILE_W  = 16;
  localparam int GEN_W   = 16;
  localparam int CELL_W  = 3 * COORD_W;
  localparam int KEY_W   = CELL_W + TILE_W;
  localparam int BIAS_W  = 22;
  localparam int RIU_W   = 7;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int USE_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W   = COUNT_BITS + IDX_W;
  localparam int ACC_W   = (SUM_W > BIAS_W) ? SUM_W : BIAS_W;
  localparam int UCMP_W  = (USE_W > RIU_W) ? USE_W : RIU_W;

  localparam logic [GEN_W-1:0] GEN_CAP_RESET = GEN_W'(8);

  typedef enum logic [1:0] {
    REQ_CONTRA    = 2'd0,
    REQ_CELL_BIAS = 2'd1,
    REQ_TILE_BIAS = 2'd2,
    REQ_DECAY     = 2'd3
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/cctd_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request per transaction.
// ----------------------------------------------------------------------------
interface cctd_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [cctd_pkg::COORD_W-1:0] coord_x;
  logic [cctd_pkg::COORD_W-1:0] coord_y;
  logic [cctd_pkg::COORD_W-1:0] coord_z;
  logic [cctd_pkg::TILE_W-1:0]  tile_id;
  logic [cctd_pkg::GEN_W-1:0]   generation;

  modport source (
    output valid, req_type, coord_x, coord_y, coord_z, tile_id, generation,
    input  ready
  );

  modport sink (
    input  valid, req_type, coord_x, coord_y, coord_z, tile_id, generation,
    output ready
  );
endinterface

// File: sv/cctd_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface cctd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        give_up;
  logic [cctd_pkg::BIAS_W-1:0] bias;
  logic                        table_full;
  logic [cctd_pkg::RIU_W-1:0]  records_in_use;

  modport source (
    output valid, give_up, bias, table_full, records_in_use,
    input  ready
  );

  modport sink (
    input  valid, give_up, bias, table_full, records_in_use,
    output ready
  );
endinterface

// File: sv/conflict_count_table_with_decay.sv
// ----------------------------------------------------------------------------
// Conflict count table with decay
// Associative table of failure records keyed by cell and tile, with counts.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch as valid/ready transactions: contradiction,
// cell bias query, cell-tile bias query or decay of all records. Each
// request produces exactly one result transaction on out_ch.
// Every request reads the whole record memory once, one entry per cycle
// through its single read port. After the scan come the DRAIN and COMMIT
// states, then OUT loads the result and the block returns to idle to
// accept again; one request is in work at a time. in_ch.ready is high
// while the block is idle, also while an earlier result still waits in the
// output register. When the receiver stalls, the result is held in out_ch
// and the next request finishes its scan and waits until that result is
// taken.
// cfg_we and cfg_wdata write the generation cap, used by contradictions.
// Reset (rst_n low at a clock edge) empties the table, drops any held
// result and sets the generation cap to 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
module conflict_count_table_with_decay (
  input  logic                        clk,
  input  logic                        rst_n,
  cctd_in_if.sink                     in_ch,
  cctd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [cctd_pkg::GEN_W-1:0]  cfg_wdata
);

  cctd_pkg::cmd_t cmd;
  cctd_pkg::sts_t sts;

  cctd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cctd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_req_type        (in_ch.req_type),
    .in_coord_x         (in_ch.coord_x),
    .in_coord_y         (in_ch.coord_y),
    .in_coord_z         (in_ch.coord_z),
    .in_tile_id         (in_ch.tile_id),
    .in_generation      (in_ch.generation),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_give_up        (out_ch.give_up),
    .out_bias           (out_ch.bias),
    .out_table_full     (out_ch.table_full),
    .out_records_in_use (out_ch.records_in_use)
  );

endmodule

// File: sv/cctd_ctrl.sv
// ----------------------------------------------------------------------------
// Conflict count table controller
// Sequences capture, table scan, commit and result hand-off.
// ----------------------------------------------------------------------------
module cctd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cctd_pkg::sts_t sts,
  output cctd_pkg::cmd_t cmd
);

  cctd_pkg::state_t state_r;
  cctd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cctd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      cctd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = cctd_pkg::ST_SCAN;
        end
      end
      cctd_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = cctd_pkg::ST_DRAIN;
        end
      end
      cctd_pkg::ST_DRAIN: begin
        state_nxt = cctd_pkg::ST_COMMIT;
      end
      cctd_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = cctd_pkg::ST_OUT;
      end
      cctd_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = cctd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cctd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/cctd_dp.sv
// ----------------------------------------------------------------------------
// Conflict count table datapath
// Record memory, valid bits, scan pipeline, accumulators and result register.
// ----------------------------------------------------------------------------
module cctd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cctd_pkg::cmd_t                    cmd,
  output cctd_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [cctd_pkg::GEN_W-1:0]        cfg_wdata,
  input  logic [1:0]                        in_req_type,
  input  logic [cctd_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [cctd_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [cctd_pkg::COORD_W-1:0]      in_coord_z,
  input  logic [cctd_pkg::TILE_W-1:0]       in_tile_id,
  input  logic [cctd_pkg::GEN_W-1:0]        in_generation,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_give_up,
  output logic [cctd_pkg::BIAS_W-1:0]       out_bias,
  output logic                              out_table_full,
  output logic [cctd_pkg::RIU_W-1:0]        out_records_in_use
);

  cctd_pkg::record_t mem [cctd_pkg::TABLE_ENTRIES];

  logic [cctd_pkg::TABLE_ENTRIES-1:0]  valid_r;
  logic [cctd_pkg::USE_W-1:0]          use_r;
  logic [cctd_pkg::GEN_W-1:0]          cap_r;

  cctd_pkg::req_t                      req_r;
  logic [cctd_pkg::KEY_W-1:0]          key_r;
  logic [cctd_pkg::GEN_W-1:0]          gen_r;

  logic [cctd_pkg::IDX_W-1:0]          rd_idx_r;
  logic [cctd_pkg::IDX_W-1:0]          cmp_idx_r;
  logic                                cmp_vld_r;
  cctd_pkg::record_t                   rd_data_r;

  logic                                hit_r;
  logic [cctd_pkg::IDX_W-1:0]          hit_idx_r;
  logic [cctd_pkg::COUNT_BITS-1:0]     hit_cnt_r;
  logic                                free_r;
  logic [cctd_pkg::IDX_W-1:0]          free_idx_r;
  logic [cctd_pkg::ACC_W-1:0]          acc_r;
  logic                                full_r;

  logic                                out_valid_r;
  logic                                give_up_r;
  logic [cctd_pkg::BIAS_W-1:0]         bias_r;
  logic                                table_full_r;
  logic [cctd_pkg::RIU_W-1:0]          riu_r;

  logic                                vbit;
  logic                                key_hit;
  logic                                cell_hit;
  logic [cctd_pkg::COUNT_BITS-1:0]     half_cnt;
  logic                                decay_wr;
  logic                                decay_free;
  logic                                ins_new;
  logic                                wr_en;
  logic [cctd_pkg::IDX_W-1:0]          wr_idx;
  cctd_pkg::record_t                   wr_data;
  logic [cctd_pkg::COUNT_BITS-1:0]     inc_cnt;
  logic                                give_up_nxt;
  logic [cctd_pkg::BIAS_W-1:0]         bias_nxt;
  logic [cctd_pkg::RIU_W-1:0]          riu_nxt;
  logic [cctd_pkg::UCMP_W-1:0]         use_ext;
  logic [cctd_pkg::BIAS_W-1:0]         bias_max;

  assign sts.rd_last  = (rd_idx_r == cctd_pkg::IDX_W'(cctd_pkg::TABLE_ENTRIES - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Compare stage for the entry read in the previous cycle.
  assign vbit     = cmp_vld_r && valid_r[cmp_idx_r];
  assign key_hit  = vbit && (rd_data_r.key == key_r);
  assign cell_hit = vbit && (rd_data_r.key[cctd_pkg::CELL_W-1:0] ==
                             key_r[cctd_pkg::CELL_W-1:0]);
  assign half_cnt   = rd_data_r.count >> 1;
  assign decay_wr   = vbit && (req_r == cctd_pkg::REQ_DECAY);
  assign decay_free = decay_wr && (half_cnt == '0);

  assign inc_cnt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign ins_new = cmd.commit && (req_r == cctd_pkg::REQ_CONTRA) && !hit_r && free_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmp_idx_r;
    wr_data = '{key: rd_data_r.key, count: half_cnt};
    if (decay_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit && (req_r == cctd_pkg::REQ_CONTRA)) begin
      if (hit_r) begin
        wr_en   = 1'b1;
        wr_idx  = hit_idx_r;
        wr_data = '{key: key_r, count: inc_cnt};
      end else if (free_r) begin
        wr_en   = 1'b1;
        wr_idx  = free_idx_r;
        wr_data = '{key: key_r, count: cctd_pkg::COUNT_BITS'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      use_r   <= '0;
      cap_r   <= cctd_pkg::GEN_CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (decay_free) begin
        valid_r[cmp_idx_r] <= 1'b0;
        use_r              <= use_r - 1'b1;
      end else if (ins_new) begin
        valid_r[free_idx_r] <= 1'b1;
        use_r               <= use_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.capture) begin
        rd_idx_r <= '0;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (cmd.capture) begin
      req_r  <= cctd_pkg::req_t'(in_req_type);
      key_r  <= {in_tile_id, in_coord_z, in_coord_y, in_coord_x};
      gen_r  <= in_generation;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      acc_r  <= '0;
      full_r <= 1'b0;
    end else begin
      if (cmp_vld_r) begin
        case (req_r)
          cctd_pkg::REQ_CONTRA: begin
            if (key_hit) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cmp_idx_r;
              hit_cnt_r <= rd_data_r.count;
            end
            if (!valid_r[cmp_idx_r] && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= cmp_idx_r;
            end
          end
          cctd_pkg::REQ_CELL_BIAS: begin
            if (cell_hit) begin
              acc_r <= acc_r + cctd_pkg::ACC_W'(rd_data_r.count);
            end
          end
          cctd_pkg::REQ_TILE_BIAS: begin
            if (key_hit) begin
              acc_r <= cctd_pkg::ACC_W'(rd_data_r.count);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit && (req_r == cctd_pkg::REQ_CONTRA) && !hit_r && !free_r) begin
        full_r <= 1'b1;
      end
    end
  end

  assign bias_max = '1;
  assign use_ext  = cctd_pkg::UCMP_W'(use_r);

  always_comb begin
    give_up_nxt = 1'b0;
    bias_nxt    = '0;
    if (req_r == cctd_pkg::REQ_CONTRA) begin
      give_up_nxt = !(({1'b0, gen_r} + 1'b1) < {1'b0, cap_r});
    end
    if ((req_r == cctd_pkg::REQ_CELL_BIAS) || (req_r == cctd_pkg::REQ_TILE_BIAS)) begin
      bias_nxt = (acc_r > cctd_pkg::ACC_W'(bias_max)) ? bias_max
                                                      : acc_r[cctd_pkg::BIAS_W-1:0];
    end
    riu_nxt = (use_ext > cctd_pkg::UCMP_W'({cctd_pkg::RIU_W{1'b1}})) ?
              {cctd_pkg::RIU_W{1'b1}} : use_ext[cctd_pkg::RIU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      give_up_r    <= give_up_nxt;
      bias_r       <= bias_nxt;
      table_full_r <= full_r;
      riu_r        <= riu_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_give_up        = give_up_r;
  assign out_bias           = bias_r;
  assign out_table_full     = table_full_r;
  assign out_records_in_use = riu_r;

endmodule
